// ===== rtl/core/risc_subset_instruction_executor_assert.svh =====
// Assertion macros for the instruction executor; they compile to nothing under synthesis.
`ifndef RISC_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RISC_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is high.
`define RSIE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RSIE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSIE_ASSERT(label, clk, rst, prop, msg)
`define RSIE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/rsie_pkg.sv =====
// Types, constants and helpers shared by the instruction executor.
`timescale 1ns / 1ps

package rsie_pkg;

   localparam int XLEN               = 32;
   localparam int PC_W               = 9;
   localparam int REG_FIELD_W        = 5;
   localparam int TARGET_W           = 8;
   localparam int MEMORY_BYTES       = 4096;
   localparam int MEM_AW             = $clog2(MEMORY_BYTES);
   localparam int DMEM_BANKS         = 4;
   localparam int DMEM_ROWS          = MEMORY_BYTES / DMEM_BANKS;
   localparam int DMEM_RW            = MEM_AW - 2;
   localparam int REGISTER_COUNT_DEF = 32;
   localparam int PROGRAM_DEPTH_DEF  = 256;
   localparam int CSR_AW             = 3;
   localparam int CSR_DW             = 32;

   localparam logic CSR_IDX_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_BNE,
      OP_JAL,
      OP_LW,
      OP_SW,
      OP_ADDI,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_EXEC,
      ST_LOOP,
      ST_DONE
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [REG_FIELD_W-1:0]   first_reg;
      logic [REG_FIELD_W-1:0]   second_reg;
      logic [REG_FIELD_W-1:0]   third_reg;
      logic signed [XLEN-1:0]   immediate;
      logic [MEM_AW-1:0]        mem_address;
      logic [TARGET_W-1:0]      jump_target;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic                     reg_written;
      logic signed [XLEN-1:0]   write_value;
      status_type               status;
   } rsp_type;

   // Register number modulo the file size, by restoring subtraction.
   function automatic logic [REG_FIELD_W-1:0] reg_wrap(
      input logic [REG_FIELD_W-1:0] r,
      input int unsigned            count
   );
      logic [9:0] v;
      v = {5'b0, r};
      for (int k = 4; k >= 0; k--) begin
         if (v >= 10'(count << k)) begin
            v = v - 10'(count << k);
         end
      end
      return v[REG_FIELD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/risc_subset_instruction_executor.sv =====
// Top level of the instruction executor: register file, byte memory, pc and visited marks.
`timescale 1ns / 1ps
`include "risc_subset_instruction_executor_assert.svh"

// Executes one decoded instruction per req_ transfer and returns one rsp_ transfer
// with the next pc, the register write and a status (executed, loop found, ended).
// The supplier feeds the instruction found at the returned next_pc.
// Path: an accepted request is held in the execute registers, and its result then
// goes to the output register. Throughput: one instruction per cycle while rsp_stall
// is low; register file, byte memory and visited marks are synchronous memories
// read at the accept edge and written back as the instruction leaves execute, with
// a forwarding register on each for the write that lands with the following read.
// Reset: the sweep clears the MEMORY_BYTES/4 rows of the byte banks, the register
// file and the visited marks, one row a cycle; req_stall stays high meanwhile.
// The csr_ port (program_length at address 0) is taken at any time.
// Stall: a result waits in the output register while rsp_stall is high; one more
// instruction can sit in execute behind it, then req_stall rises.
// Once halted, each instruction is answered with its status and ignored.
module risc_subset_instruction_executor #(
   parameter int REGISTER_COUNT = rsie_pkg::REGISTER_COUNT_DEF,
   parameter int PROGRAM_DEPTH  = rsie_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rsie_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rsie_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rsie_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rsie_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rsie_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import rsie_pkg::*;

   localparam int RF_AW     = $clog2(REGISTER_COUNT);
   localparam int VIS_AW    = $clog2(PROGRAM_DEPTH);
   localparam int SWEEP_A   = (DMEM_ROWS > PROGRAM_DEPTH) ? DMEM_ROWS : PROGRAM_DEPTH;
   localparam int SWEEP_LEN = (SWEEP_A > REGISTER_COUNT) ? SWEEP_A : REGISTER_COUNT;
   localparam int SWP_W     = $clog2(SWEEP_LEN);

   // configuration
   logic [PC_W-1:0] len_ff;
   logic            csr_wr;

   // clearing sweep
   logic             clr_active_ff, clr_active_in;
   logic [SWP_W-1:0] sweep_cnt_ff, sweep_cnt_in;

   // architectural control state
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            halted_ff, halted_in;

   // handshake
   logic req_accept, x_fire;
   logic x_valid_ff, x_valid_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   // request-side addresses
   logic [RF_AW-1:0]   req_rd, req_rs1, req_rs2, rf_ra, rf_rb;
   logic [DMEM_RW-1:0] dm_ra [DMEM_BANKS];

   // execute stage payload
   op_type             x_op_ff;
   logic [RF_AW-1:0]   x_rd_ff, x_ra_ff, x_rb_ff;
   logic [XLEN-1:0]    x_imm_ff;
   logic [1:0]         x_alo_ff;
   logic [DMEM_RW-1:0] x_row_ff [DMEM_BANKS];
   logic [TARGET_W-1:0] x_target_ff;

   // memory read data
   logic [XLEN-1:0] rf_rd_a_ff, rf_rd_b_ff;
   logic [7:0]      dm_rd_ff [DMEM_BANKS];
   logic            vis_rd_ff;

   // forwarding of the write that lands with the next read
   logic               rf_fw_valid_ff;
   logic [RF_AW-1:0]   rf_fw_addr_ff;
   logic [XLEN-1:0]    rf_fw_data_ff;
   logic               dm_fw_valid_ff;
   logic [DMEM_RW-1:0] dm_fw_row_ff [DMEM_BANKS];
   logic [7:0]         dm_fw_byte_ff [DMEM_BANKS];
   logic               vis_fw_valid_ff;
   logic [VIS_AW-1:0]  vis_fw_idx_ff;

   // execute results
   logic [XLEN-1:0]   opa, opb, x_wval, load_val;
   logic [7:0]        bank_byte [DMEM_BANKS];
   logic [7:0]        st_byte [DMEM_BANKS];
   logic              marked, end_now, x_exec, x_rf_we, x_mem_we;
   logic [PC_W-1:0]   x_pc_next;
   logic              x_halt_next;
   status_type        x_status;
   logic [VIS_AW-1:0] x_vis_idx;

   // memory write ports
   logic               rf_we;
   logic [RF_AW-1:0]   rf_wa;
   logic [XLEN-1:0]    rf_wd;
   logic               vis_we;
   logic [VIS_AW-1:0]  vis_wa;
   logic               vis_wd;
   logic [VIS_AW-1:0]  vis_ra;
   logic [DMEM_BANKS-1:0] dm_we;
   logic [DMEM_RW-1:0] dm_wa [DMEM_BANKS];
   logic [7:0]         dm_wd [DMEM_BANKS];

   // ---------------- handshake ----------------
   assign x_fire     = x_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = clr_active_ff || (x_valid_ff && !x_fire);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      x_valid_in   = req_accept ? 1'b1 : (x_fire ? 1'b0 : x_valid_ff);
      out_valid_in = x_fire ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_LENGTH) ? CSR_DW'(len_ff) : '0;

   // ---------------- clearing sweep ----------------
   always_comb begin
      clr_active_in = clr_active_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      if (clr_active_ff) begin
         if (32'(sweep_cnt_ff) == SWEEP_LEN - 1) begin
            clr_active_in = 1'b0;
         end else begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- request decode ----------------
   always_comb begin
      req_rd  = RF_AW'(reg_wrap(req_data.first_reg, REGISTER_COUNT));
      req_rs1 = RF_AW'(reg_wrap(req_data.second_reg, REGISTER_COUNT));
      req_rs2 = RF_AW'(reg_wrap(req_data.third_reg, REGISTER_COUNT));
      // port A: stored or first compared register, else first source
      rf_ra = (req_data.op == OP_BNE || req_data.op == OP_SW) ? req_rd : req_rs1;
      rf_rb = (req_data.op == OP_BNE) ? req_rs1 : req_rs2;
      // bank b holds the byte at mem_address + ((b - mem_address) mod 4)
      for (int b = 0; b < DMEM_BANKS; b++) begin
         dm_ra[b] = req_data.mem_address[MEM_AW-1:2]
                    + DMEM_RW'(2'(b) < req_data.mem_address[1:0]);
      end
   end

   // visited mark of the pc the accepted item runs at
   assign pc_in  = x_fire ? x_pc_next : pc_ff;
   assign vis_ra = VIS_AW'(pc_in);

   // ---------------- execute ----------------
   assign x_vis_idx = VIS_AW'(pc_ff);

   always_comb begin
      opa = (rf_fw_valid_ff && rf_fw_addr_ff == x_ra_ff) ? rf_fw_data_ff : rf_rd_a_ff;
      opb = (rf_fw_valid_ff && rf_fw_addr_ff == x_rb_ff) ? rf_fw_data_ff : rf_rd_b_ff;
      for (int b = 0; b < DMEM_BANKS; b++) begin
         bank_byte[b] = (dm_fw_valid_ff && dm_fw_row_ff[b] == x_row_ff[b])
                        ? dm_fw_byte_ff[b] : dm_rd_ff[b];
      end
      for (int k = 0; k < DMEM_BANKS; k++) begin
         load_val[8*k +: 8] = bank_byte[2'(k) + x_alo_ff];
      end
      // byte lane offset wraps at two bits
      for (int b = 0; b < DMEM_BANKS; b++) begin
         st_byte[b] = opa[{2'(2'(b) - x_alo_ff), 3'b000} +: 8];
      end
   end

   always_comb begin
      marked   = vis_rd_ff || (vis_fw_valid_ff && vis_fw_idx_ff == x_vis_idx);
      end_now  = (32'(pc_ff) >= 32'(len_ff)) || (32'(pc_ff) >= 32'(PROGRAM_DEPTH));
      x_exec      = 1'b0;
      x_rf_we     = 1'b0;
      x_mem_we    = 1'b0;
      x_wval      = '0;
      x_pc_next   = pc_ff;
      x_halt_next = halted_ff;
      x_status    = ST_EXEC;
      priority if (halted_ff) begin
         x_status = end_now ? ST_DONE : ST_LOOP;
      end else if (end_now) begin
         x_halt_next = 1'b1;
         x_status    = ST_DONE;
      end else if (marked) begin
         x_halt_next = 1'b1;
         x_status    = ST_LOOP;
      end else begin
         x_exec    = 1'b1;
         x_pc_next = pc_ff + 1'b1;
         unique case (x_op_ff)
            OP_ADD: begin
               x_wval  = opa + opb;
               x_rf_we = 1'b1;
            end
            OP_SUB: begin
               x_wval  = opa - opb;
               x_rf_we = 1'b1;
            end
            OP_BNE: begin
               if (opa != opb) begin
                  x_pc_next = PC_W'(x_target_ff);
               end
            end
            OP_JAL: begin
               x_pc_next = PC_W'(x_target_ff);
            end
            OP_LW: begin
               x_wval  = load_val;
               x_rf_we = 1'b1;
            end
            OP_SW: begin
               x_mem_we = 1'b1;
            end
            OP_ADDI: begin
               x_wval  = opa + x_imm_ff;
               x_rf_we = 1'b1;
            end
            OP_NOP: begin
            end
         endcase
      end
   end

   // ---------------- memory write ports ----------------
   always_comb begin
      rf_we  = 1'b0;
      rf_wa  = x_rd_ff;
      rf_wd  = x_wval;
      vis_we = 1'b0;
      vis_wa = x_vis_idx;
      vis_wd = 1'b1;
      if (clr_active_ff) begin
         rf_we  = 32'(sweep_cnt_ff) < REGISTER_COUNT;
         rf_wa  = RF_AW'(sweep_cnt_ff);
         rf_wd  = '0;
         vis_we = 32'(sweep_cnt_ff) < PROGRAM_DEPTH;
         vis_wa = VIS_AW'(sweep_cnt_ff);
         vis_wd = 1'b0;
      end else begin
         rf_we  = x_fire && x_rf_we;
         vis_we = x_fire && x_exec;
      end
      for (int b = 0; b < DMEM_BANKS; b++) begin
         if (clr_active_ff) begin
            dm_we[b] = 32'(sweep_cnt_ff) < DMEM_ROWS;
            dm_wa[b] = DMEM_RW'(sweep_cnt_ff);
            dm_wd[b] = '0;
         end else begin
            dm_we[b] = x_fire && x_mem_we;
            dm_wa[b] = x_row_ff[b];
            dm_wd[b] = st_byte[b];
         end
      end
   end

   // ---------------- memories ----------------
   logic [XLEN-1:0] rf_mem [REGISTER_COUNT];

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      if (req_accept) begin
         rf_rd_a_ff <= rf_mem[rf_ra];
         rf_rd_b_ff <= rf_mem[rf_rb];
      end
   end

   logic vis_mem [PROGRAM_DEPTH];

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (req_accept) begin
         vis_rd_ff <= vis_mem[vis_ra];
      end
   end

   for (genvar gb = 0; gb < DMEM_BANKS; gb++) begin : g_bank
      logic [7:0] bank_mem [DMEM_ROWS];

      always_ff @(posedge clock) begin
         if (dm_we[gb]) begin
            bank_mem[dm_wa[gb]] <= dm_wd[gb];
         end
         if (req_accept) begin
            dm_rd_ff[gb] <= bank_mem[dm_ra[gb]];
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_op_ff     <= req_data.op;
         x_rd_ff     <= req_rd;
         x_ra_ff     <= rf_ra;
         x_rb_ff     <= rf_rb;
         x_imm_ff    <= req_data.immediate;
         x_alo_ff    <= req_data.mem_address[1:0];
         x_target_ff <= req_data.jump_target;
         for (int b = 0; b < DMEM_BANKS; b++) begin
            x_row_ff[b] <= dm_ra[b];
         end
      end
      if (x_fire) begin
         out_data_ff.next_pc     <= x_pc_next;
         out_data_ff.reg_written <= x_rf_we;
         out_data_ff.write_value <= $signed(x_wval);
         out_data_ff.status      <= x_status;
      end
      if (x_fire && x_rf_we) begin
         rf_fw_addr_ff <= x_rd_ff;
         rf_fw_data_ff <= x_wval;
      end
      if (x_fire && x_mem_we) begin
         for (int b = 0; b < DMEM_BANKS; b++) begin
            dm_fw_row_ff[b]  <= x_row_ff[b];
            dm_fw_byte_ff[b] <= st_byte[b];
         end
      end
      if (x_fire && x_exec) begin
         vis_fw_idx_ff <= x_vis_idx;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= '0;
         clr_active_ff   <= 1'b1;
         sweep_cnt_ff    <= '0;
         pc_ff           <= '0;
         halted_ff       <= 1'b0;
         x_valid_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         rf_fw_valid_ff  <= 1'b0;
         dm_fw_valid_ff  <= 1'b0;
         vis_fw_valid_ff <= 1'b0;
      end else begin
         if (csr_wr && csr_paddr[2] == CSR_IDX_LENGTH) begin
            len_ff <= csr_pwdata[PC_W-1:0];
         end
         clr_active_ff <= clr_active_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         pc_ff         <= pc_in;
         halted_ff     <= x_fire ? x_halt_next : halted_ff;
         x_valid_ff    <= x_valid_in;
         out_valid_ff  <= out_valid_in;
         if (x_fire && x_rf_we) begin
            rf_fw_valid_ff <= 1'b1;
         end
         if (x_fire && x_mem_we) begin
            dm_fw_valid_ff <= 1'b1;
         end
         if (x_fire && x_exec) begin
            vis_fw_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------- assertions ----------------
   `RSIE_ASSERT(a_halt_sticky, clock, reset, halted_ff |=> halted_ff, "halt flag dropped")
   `RSIE_ASSERT(a_halted_no_write, clock, reset, (x_fire && halted_ff) |-> (!rf_we && !vis_we && dm_we == '0), "halted core wrote state")
   `RSIE_ASSERT(a_halt_keeps_pc, clock, reset, (x_fire && x_status != ST_EXEC) |-> (x_pc_next == pc_ff), "pc moved on a halting step")
   `RSIE_ASSERT_ALWAYS(a_sweep_idle, clock, clr_active_ff |-> (!x_valid_ff && !out_valid_ff), "work in flight during clearing sweep")

endmodule
